### sv/gslmd_pkg.sv
// Package for the grid strict local minimum detector.
// Holds request/result payload types, command codes and sizing constants.
// No dependencies.
`timescale 1ns / 1ps

package gslmd_pkg;

  // Largest supported grid edge, and the index width of the column store.
  localparam int MAX_SIZE = 64;
  localparam int IDX_W    = $clog2(MAX_SIZE);

  // Field widths fixed by the interface.
  localparam int CNT_W    = 7;
  localparam int SAMPLE_W = 16;

  localparam logic [CNT_W-1:0] SIZE_MIN   = CNT_W'(2);
  localparam logic [CNT_W-1:0] SIZE_MAX   = CNT_W'(MAX_SIZE);
  localparam logic [CNT_W-1:0] SIZE_RESET = CNT_W'(8);

  typedef enum logic {
    CMD_ELEM  = 1'b0,
    CMD_FLUSH = 1'b1
  } gslmd_cmd_t;

  typedef struct packed {
    gslmd_cmd_t                  cmd;
    logic signed [SAMPLE_W-1:0]  sample;
  } gslmd_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0]  min_value;
    logic [CNT_W-1:0]            min_row;
    logic [CNT_W-1:0]            min_col;
  } gslmd_result_t;

endpackage

### sv/grid_strict_local_minimum_detector_top.sv
// Top level of the grid strict local minimum detector (4-neighborhood).
// Column store, position counters, compare logic and result skid buffer.
// Depends on gslmd_pkg.
`timescale 1ns / 1ps

// Usage
//   Request channel (item_valid / item_stall / item): grid elements in raster
//   order with cmd = CMD_ELEM, then grid_size flush requests (cmd = CMD_FLUSH)
//   to decide the last row. Early flushes and surplus elements are dropped.
//   Result channel (result_valid / result_stall / result): every element that
//   is strictly below all of its existing up/down/left/right neighbors, in
//   raster order, with 1-based row and column.
//   cfg_we / cfg_data write grid_size (clamped to 2..MAX_SIZE) and restart
//   the grid; write only while the block is idle.
// Timing
//   Element (r, c) is decided by the request at (r+1, c), or by flush c for
//   the last row; a hit is in the result register right after the edge that
//   accepts that request, if that register is free. One request per cycle
//   while not stalled: the column store is read through two registered ports addressed by the next position.
// Reset and stall
//   rst (synchronous) restores grid_size = 8 and the start of a grid, empties
//   the result path and holds item_stall high. Column store is not cleared.
//   While a result waits in the result register, requests are still taken;
//   the next hit goes to a skid register and item_stall stays high until
//   the skid register empties.

module grid_strict_local_minimum_detector_top (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cfg_we,
  input  logic [gslmd_pkg::CNT_W-1:0]               cfg_data,
  input  logic                                      item_valid,
  output logic                                      item_stall,
  input  gslmd_pkg::gslmd_item_t                    item,
  output logic                                      result_valid,
  input  logic                                      result_stall,
  output gslmd_pkg::gslmd_result_t                  result
);

  localparam int CW = gslmd_pkg::CNT_W;
  localparam int IW = gslmd_pkg::IDX_W;
  localparam int SW = gslmd_pkg::SAMPLE_W;

  // One store word per column: newest row on top, the row before below.
  typedef struct packed {
    logic signed [SW-1:0] top;
    logic signed [SW-1:0] bot;
  } col_word_t;

  // Configuration and position state.
  logic [CW-1:0] grid_size;
  logic [CW-1:0] n_eff;
  logic [CW-1:0] row_count, row_count_next;
  logic [CW-1:0] col_count, col_count_next;
  logic [CW-1:0] flush_count, flush_count_next;
  logic          grid_done;

  // Request qualification.
  logic acc, elem_acc, flush_acc;

  // Column store and its read path.
  col_word_t     col_mem [gslmd_pkg::MAX_SIZE];
  col_word_t     ctr_q, rgt_q, byp_word;
  logic          ctr_byp, rgt_byp;
  col_word_t     ctr_word, rgt_word, wr_word;
  logic [CW-1:0] rd_col;
  logic [IW-1:0] ctr_idx, rgt_idx, wr_idx;

  // Decision.
  logic signed [SW-1:0] left_val;
  logic signed [SW-1:0] v_val;
  logic [CW-1:0]        d_row, d_col;
  logic                 has_up, has_down, decide, hit, res_hit;
  gslmd_pkg::gslmd_result_t res;

  // Output register plus skid.
  gslmd_pkg::gslmd_result_t skid;
  logic skid_valid, skid_valid_next, result_valid_next;
  logic out_take, out_free, load_out_res, load_skid, load_out_skid;

  // ---------------------------------------------------------------------
  // Size clamp and request qualification
  // ---------------------------------------------------------------------
  always_comb begin
    if (grid_size < gslmd_pkg::SIZE_MIN) begin
      n_eff = gslmd_pkg::SIZE_MIN;
    end else if (grid_size > gslmd_pkg::SIZE_MAX) begin
      n_eff = gslmd_pkg::SIZE_MAX;
    end else begin
      n_eff = grid_size;
    end
  end

  assign grid_done  = (row_count > n_eff);
  assign item_stall = skid_valid || rst;
  assign acc        = item_valid && !item_stall && !rst;
  assign elem_acc   = acc && (item.cmd == gslmd_pkg::CMD_ELEM) && !grid_done;
  assign flush_acc  = acc && (item.cmd == gslmd_pkg::CMD_FLUSH) && grid_done;

  // ---------------------------------------------------------------------
  // Position counters. Reset and config writes both restart the grid.
  // ---------------------------------------------------------------------
  always_comb begin
    row_count_next   = row_count;
    col_count_next   = col_count;
    flush_count_next = flush_count;
    if (rst || cfg_we) begin
      row_count_next   = CW'(1);
      col_count_next   = CW'(1);
      flush_count_next = '0;
    end else if (elem_acc) begin
      if (col_count >= n_eff) begin
        col_count_next = CW'(1);
        row_count_next = row_count + CW'(1);
      end else begin
        col_count_next = col_count + CW'(1);
      end
    end else if (flush_acc) begin
      if ((flush_count + CW'(1)) >= n_eff) begin
        row_count_next   = CW'(1);
        col_count_next   = CW'(1);
        flush_count_next = '0;
      end else begin
        flush_count_next = flush_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size   <= gslmd_pkg::SIZE_RESET;
      row_count   <= CW'(1);
      col_count   <= CW'(1);
      flush_count <= '0;
    end else begin
      if (cfg_we) begin
        grid_size <= cfg_data;
      end
      row_count   <= row_count_next;
      col_count   <= col_count_next;
      flush_count <= flush_count_next;
    end
  end

  // ---------------------------------------------------------------------
  // Column store. Reads prefetch the column of the next request and the
  // one to its right; a same-edge write to either address is bypassed.
  // ---------------------------------------------------------------------
  assign rd_col  = (row_count_next > n_eff) ? (flush_count_next + CW'(1)) : col_count_next;
  assign ctr_idx = IW'(rd_col - CW'(1));
  assign rgt_idx = IW'(rd_col);
  assign wr_idx  = IW'(col_count - CW'(1));
  assign wr_word = '{top: item.sample, bot: ctr_word.top};

  always_ff @(posedge clk) begin
    if (elem_acc) begin
      col_mem[wr_idx] <= wr_word;
    end
    ctr_q    <= col_mem[ctr_idx];
    rgt_q    <= col_mem[rgt_idx];
    byp_word <= wr_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctr_byp <= 1'b0;
      rgt_byp <= 1'b0;
    end else begin
      ctr_byp <= elem_acc && (wr_idx == ctr_idx);
      rgt_byp <= elem_acc && (wr_idx == rgt_idx);
    end
  end

  assign ctr_word = ctr_byp ? byp_word : ctr_q;
  assign rgt_word = rgt_byp ? byp_word : rgt_q;

  // ---------------------------------------------------------------------
  // Decision: element above the incoming one, or last-row element on flush.
  // ---------------------------------------------------------------------
  always_comb begin
    if (flush_acc) begin
      d_row    = n_eff;
      d_col    = flush_count + CW'(1);
      has_up   = 1'b1;
      has_down = 1'b0;
    end else begin
      d_row    = row_count - CW'(1);
      d_col    = col_count;
      has_up   = (row_count > CW'(2));
      has_down = 1'b1;
    end
  end

  assign v_val  = ctr_word.top;
  assign decide = flush_acc || (elem_acc && (row_count >= CW'(2)));

  assign hit = (!has_up || ($signed(v_val) < $signed(ctr_word.bot))) &&
               ((d_col <= CW'(1)) || ($signed(v_val) < $signed(left_val))) &&
               ((d_col >= n_eff) || ($signed(v_val) < $signed(rgt_word.top))) &&
               (!has_down || ($signed(v_val) < $signed(item.sample)));

  assign res_hit = decide && hit;
  assign res     = '{min_value: v_val, min_row: d_row, min_col: d_col};

  // Center of this decision is the left neighbor of the next one in the row.
  always_ff @(posedge clk) begin
    if (elem_acc || flush_acc) begin
      left_val <= v_val;
    end
  end

  // ---------------------------------------------------------------------
  // Result register and skid
  // ---------------------------------------------------------------------
  assign out_take      = result_valid && !result_stall;
  assign out_free      = !result_valid || out_take;
  assign load_out_res  = res_hit && out_free;
  assign load_skid     = res_hit && !out_free;
  assign load_out_skid = out_take && skid_valid;

  assign result_valid_next = load_out_res || load_out_skid || (result_valid && !out_take);
  assign skid_valid_next   = load_skid || (skid_valid && !load_out_skid);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      result_valid <= result_valid_next;
      skid_valid   <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out_res) begin
      result <= res;
    end else if (load_out_skid) begin
      result <= skid;
    end
    if (load_skid) begin
      skid <= res;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid holds a result while the result register is empty");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (row_count == CW'(1) && col_count == CW'(1) && flush_count == '0))
    else $error("config write did not restart the grid");

  a_result_from_req: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(acc))
    else $error("result appeared without an accepted request");

  a_flush_after_grid: assert property (@(posedge clk) disable iff (rst)
    (flush_count != '0) |-> grid_done)
    else $error("flush count advanced before the grid was complete");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    (col_count >= CW'(1)) && (col_count <= n_eff))
    else $error("column counter out of range");

endmodule

### bench/grid_strict_local_minimum_detector_top_tb.sv
// Self-checking bench for grid_strict_local_minimum_detector_top.
// Predicts every strict local minimum from accepted requests and checks results in order.
// Depends on gslmd_pkg and the detector top level.
`timescale 1ns / 1ps

module grid_strict_local_minimum_detector_top_tb;

  localparam int HALF_PERIOD = 5;
  localparam int HOLD_CYCLES = 300;     // long output hold-off
  localparam int SETTLE_CYCLES = 8;     // block latency plus skid, with margin
  localparam int RUN_LIMIT_NS = 2000000;
  localparam int PRINT_CAP = 40;

  // Receiver stall modes.
  typedef enum int {
    RX_OPEN,
    RX_RANDOM,
    RX_PERIODIC
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [gslmd_pkg::CNT_W-1:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_stall;
  gslmd_pkg::gslmd_item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  gslmd_pkg::gslmd_result_t result;

  grid_strict_local_minimum_detector_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Grid tracker: own copy of the two-row line store, the size register and
  // the raster position. Updated at the edge where a request is accepted.
  // ---------------------------------------------------------------------------
  logic signed [gslmd_pkg::SAMPLE_W-1:0] row_buf [2][gslmd_pkg::MAX_SIZE];
  logic [gslmd_pkg::CNT_W-1:0] size_reg = gslmd_pkg::SIZE_RESET;
  int row_pos = 1;
  int col_pos = 1;
  int flush_pos = 0;

  gslmd_pkg::gslmd_result_t min_expected[$];

  // Run bookkeeping.
  int mismatches = 0;
  int minima_checked = 0;
  int requests_sent = 0;
  int grids_done = 0;
  int size_writes = 0;

  // Sender and receiver behavior, set by the test tasks.
  bit idle_on = 1'b0;
  int burst_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int rx_tick = 0;
  bit hold_req = 1'b0;
  logic hold_on = 1'b0;

  // Sizes below 2 act as 2, above MAX_SIZE as MAX_SIZE.
  function automatic int grid_edge();
    if (size_reg < gslmd_pkg::SIZE_MIN) return int'(gslmd_pkg::SIZE_MIN);
    if (size_reg > gslmd_pkg::SIZE_MAX) return int'(gslmd_pkg::SIZE_MAX);
    return int'(size_reg);
  endfunction

  function automatic void restart_grid();
    row_pos = 1;
    col_pos = 1;
    flush_pos = 0;
  endfunction

  // Element (r, c) against its existing neighbors; 'below' only when a row
  // below exists.
  function automatic bit is_strict_min(int r, int c, int n, bit has_below,
                                       logic signed [gslmd_pkg::SAMPLE_W-1:0] below,
                                       output gslmd_pkg::gslmd_result_t hit);
    logic signed [gslmd_pkg::SAMPLE_W-1:0] v;
    bit ok;
    v = row_buf[r % 2][c - 1];
    ok = 1'b1;
    if (r > 1 && !(v < row_buf[(r - 1) % 2][c - 1])) ok = 1'b0;
    if (c > 1 && !(v < row_buf[r % 2][c - 2])) ok = 1'b0;
    if (c < n && !(v < row_buf[r % 2][c])) ok = 1'b0;
    if (has_below && !(v < below)) ok = 1'b0;
    hit.min_value = v;
    hit.min_row = gslmd_pkg::CNT_W'(r);
    hit.min_col = gslmd_pkg::CNT_W'(c);
    return ok;
  endfunction

  function automatic void advance_grid_model(gslmd_pkg::gslmd_cmd_t c,
                                             logic signed [gslmd_pkg::SAMPLE_W-1:0] s);
    int n;
    gslmd_pkg::gslmd_result_t hit;
    n = grid_edge();
    if (c == gslmd_pkg::CMD_ELEM) begin
      if (row_pos > n) return;          // extra element after the grid: dropped
      if (row_pos >= 2 && is_strict_min(row_pos - 1, col_pos, n, 1'b1, s, hit))
        min_expected.push_back(hit);
      row_buf[row_pos % 2][col_pos - 1] = s;
      if (col_pos >= n) begin
        col_pos = 1;
        row_pos++;
      end else begin
        col_pos++;
      end
    end else begin
      if (row_pos <= n) return;         // early flush: dropped
      if (is_strict_min(n, flush_pos + 1, n, 1'b0, '0, hit))
        min_expected.push_back(hit);
      flush_pos++;
      if (flush_pos >= n) restart_grid();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what);
    if (mismatches < PRINT_CAP) $display("MISMATCH at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  gslmd_pkg::gslmd_result_t want;

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (min_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%0d row=%0d col=%0d",
                                  result.min_value, result.min_row, result.min_col));
      end else begin
        want = min_expected.pop_front();
        minima_checked++;
        if (result.min_value !== want.min_value)
          report_mismatch($sformatf("min_value %0d, expected %0d (row %0d col %0d)",
                                    result.min_value, want.min_value,
                                    want.min_row, want.min_col));
        if (result.min_row !== want.min_row)
          report_mismatch($sformatf("min_row %0d, expected %0d",
                                    result.min_row, want.min_row));
        if (result.min_col !== want.min_col)
          report_mismatch($sformatf("min_col %0d, expected %0d",
                                    result.min_col, want.min_col));
      end
    end
  end

  // Receiver stall: long hold-off when requested, otherwise the current mode.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (hold_on)
      result_stall <= 1'b1;
    else if (rx_mode == RX_RANDOM)
      result_stall <= ($urandom_range(0, 2) == 0);
    else if (rx_mode == RX_PERIODIC)
      result_stall <= ((rx_tick % 13) < 5);
    else
      result_stall <= 1'b0;
  end

  // Hold-off counter, in its own process.
  always begin
    wait (hold_req);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
    hold_req = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Request side. All tasks are entered and left at a rising edge.
  // ---------------------------------------------------------------------------
  task automatic send_req(gslmd_pkg::gslmd_cmd_t c,
                          logic signed [gslmd_pkg::SAMPLE_W-1:0] s);
    gslmd_pkg::gslmd_item_t req;
    int gap;
    // Bursts of random length separated by random gaps.
    if (idle_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    req.cmd = c;
    req.sample = s;
    item_valid <= 1'b1;
    item <= req;
    do @(posedge clk); while (item_stall);
    advance_grid_model(c, s);
  endtask

  // Drop valid, wait for every pending minimum, then let the block settle.
  task automatic wait_drained();
    item_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (min_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only while idle. Writing the size restarts the grid.
  task automatic write_size(logic [gslmd_pkg::CNT_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    size_reg = v;
    restart_grid();
    size_writes++;
  endtask

  // Mostly a narrow spread so that ties and minima are common.
  function automatic logic signed [gslmd_pkg::SAMPLE_W-1:0] pick_sample(int spread);
    int k;
    case ($urandom_range(0, 9))
      0: return gslmd_pkg::SAMPLE_W'($urandom);
      1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: begin
        k = int'($urandom_range(0, 2 * spread)) - spread;
        return gslmd_pkg::SAMPLE_W'(k);
      end
    endcase
  endfunction

  function automatic logic [gslmd_pkg::CNT_W-1:0] pick_size();
    case ($urandom_range(0, 19))
      0: return gslmd_pkg::CNT_W'($urandom_range(0, 1));
      1, 2: return gslmd_pkg::CNT_W'($urandom_range(9, 16));
      default: return gslmd_pkg::CNT_W'($urandom_range(2, 7));
    endcase
  endfunction

  // One grid in raster order. rows <= 0 sends the full grid plus its flushes;
  // otherwise only that many rows. noisy mixes in early flushes and surplus
  // elements, which the block drops. pause_at >= 0 stops the sender there
  // until every pending minimum has come out.
  task automatic run_grid(bit noisy, int spread, int pause_at, int rows);
    int n;
    int count;
    n = grid_edge();
    count = (rows <= 0) ? n * n : rows * n;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) begin
        item_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (min_expected.size() != 0);
      end
      if (noisy && $urandom_range(0, 39) == 0)
        send_req(gslmd_pkg::CMD_FLUSH, gslmd_pkg::SAMPLE_W'($urandom));
      send_req(gslmd_pkg::CMD_ELEM, pick_sample(spread));
      requests_sent++;
    end
    if (rows > 0) return;
    if (noisy && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3))
        send_req(gslmd_pkg::CMD_ELEM, gslmd_pkg::SAMPLE_W'($urandom));
    for (int k = 0; k < n; k++) begin
      send_req(gslmd_pkg::CMD_FLUSH, gslmd_pkg::SAMPLE_W'($urandom));
      requests_sent++;
    end
    grids_done++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-built grids: sample extremes, ties, early flush, surplus element,
  // clamped size, back-to-back grids without reset, last row via flush.
  task automatic test_directed();
    idle_on = 1'b0;
    rx_mode = RX_OPEN;
    send_req(gslmd_pkg::CMD_FLUSH, 16'h7FFF);   // early flush at reset size: dropped
    wait_drained();
    write_size(gslmd_pkg::CNT_W'(0));           // acts as 2
    send_req(gslmd_pkg::CMD_ELEM, 16'h8000);
    send_req(gslmd_pkg::CMD_ELEM, 16'h7FFF);
    send_req(gslmd_pkg::CMD_ELEM, 16'h7FFF);
    send_req(gslmd_pkg::CMD_ELEM, 16'h8000);    // (2,2) decided by the second flush
    send_req(gslmd_pkg::CMD_ELEM, 16'h1234);    // surplus element: dropped
    send_req(gslmd_pkg::CMD_FLUSH, '0);
    send_req(gslmd_pkg::CMD_FLUSH, 16'hFFFF);
    // Next grid follows directly; all ties, so nothing is strict.
    repeat (4) send_req(gslmd_pkg::CMD_ELEM, 16'sd5);
    repeat (2) send_req(gslmd_pkg::CMD_FLUSH, '0);
    requests_sent += 12;
    grids_done += 2;
    wait_drained();
    write_size(gslmd_pkg::CNT_W'(3));
    // Only the center is strict; the border nines tie with each other.
    for (int i = 0; i < 9; i++)
      send_req(gslmd_pkg::CMD_ELEM, (i == 4) ? -16'sd1 : 16'sd9);
    repeat (3) send_req(gslmd_pkg::CMD_FLUSH, '0);
    requests_sent += 12;
    grids_done++;
    wait_drained();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // so the skid fills and the request side stalls.
  task automatic test_output_hold();
    write_size(gslmd_pkg::CNT_W'(8));
    idle_on = 1'b0;
    rx_mode = RX_OPEN;
    hold_req = 1'b1;
    run_grid(1'b0, 2, -1, 0);
    wait_drained();
  endtask

  // Sender stops mid-grid until every pending minimum has come out.
  task automatic test_input_pause();
    write_size(gslmd_pkg::CNT_W'(5));
    idle_on = 1'b1;
    rx_mode = RX_RANDOM;
    run_grid(1'b0, 2, 12, 0);
    wait_drained();
  endtask

  // Largest edge (from an over-range write and an exact one) on partial
  // grids, then the smallest raw value on a full grid.
  task automatic test_size_extremes();
    idle_on = 1'b1;
    rx_mode = RX_PERIODIC;
    write_size(gslmd_pkg::CNT_W'(127));         // acts as MAX_SIZE
    run_grid(1'b0, 3, -1, 3);
    wait_drained();
    write_size(gslmd_pkg::SIZE_MAX);
    run_grid(1'b0, 1, -1, 2);
    wait_drained();
    write_size(gslmd_pkg::CNT_W'(1));           // acts as 2
    run_grid(1'b0, 1, -1, 0);
    wait_drained();
  endtask

  // Random grids, mostly small, with random size changes between grids and
  // varying sender and receiver idling.
  task automatic test_random_grids(int budget);
    int stop_at;
    stop_at = requests_sent + budget;
    while (requests_sent < stop_at) begin
      if ($urandom_range(0, 2) == 0) begin
        wait_drained();
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        idle_on = ($urandom_range(0, 3) != 0);
        write_size(pick_size());
      end
      run_grid(($urandom_range(0, 3) == 0), $urandom_range(1, 4), -1, 0);
    end
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_output_hold();
    test_input_pause();
    test_size_extremes();
    test_random_grids(1150);
    $display("Run covered %0d grids and %0d requests over %0d size writes;",
             grids_done, requests_sent, size_writes);
    $display("%0d minima compared, %0d mismatches.", minima_checked, mismatches);
    if (mismatches == 0 && min_expected.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Watchdog.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Timeout with %0d minima still pending", min_expected.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### sim.f
sv/gslmd_pkg.sv
sv/grid_strict_local_minimum_detector_top.sv
bench/grid_strict_local_minimum_detector_top_tb.sv
